FILE: rtl/core/pip_pkg.sv
package pip_pkg;

    localparam int MAX_VERTICES_DEF = 16;
    localparam int COORD_WIDTH_DEF  = 20;
    localparam int OP_W             = 2;
    localparam int CROSS_W          = 5;
    localparam int STATUS_W         = 2;
    localparam int UPC_W            = 3;

    typedef enum logic [OP_W-1:0] {
        OP_START  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK      = 2'd0,
        STATUS_EMPTY   = 2'd1,
        STATUS_DROPPED = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_LAST,
        COND_NOT_LAST,
        COND_PIPE_BUSY,
        COND_OUT_FULL
    } cond_t;

    typedef struct packed {
        logic             rd;
        logic             first;
        logic             close;
        logic             emit;
        cond_t            cond;
        logic [UPC_W-1:0] target;
    } uword_t;

    localparam logic [UPC_W-1:0] UPC_FIRST = 3'd0;
    localparam logic [UPC_W-1:0] UPC_LOOP  = 3'd1;
    localparam logic [UPC_W-1:0] UPC_CLOSE = 3'd2;
    localparam logic [UPC_W-1:0] UPC_WAIT  = 3'd3;
    localparam logic [UPC_W-1:0] UPC_EMIT  = 3'd4;

    // control store
    function automatic uword_t ucode(input logic [UPC_W-1:0] upc);
        uword_t w;
        begin
            w = '{rd: 1'b0, first: 1'b0, close: 1'b0, emit: 1'b0,
                  cond: COND_NEXT, target: UPC_FIRST};
            case (upc)
                UPC_FIRST:
                begin
                    w.rd     = 1'b1;
                    w.first  = 1'b1;
                    w.cond   = COND_LAST;
                    w.target = UPC_CLOSE;
                end
                UPC_LOOP:
                begin
                    w.rd     = 1'b1;
                    w.cond   = COND_NOT_LAST;
                    w.target = UPC_LOOP;
                end
                UPC_CLOSE:
                begin
                    w.close  = 1'b1;
                end
                UPC_WAIT:
                begin
                    w.cond   = COND_PIPE_BUSY;
                    w.target = UPC_WAIT;
                end
                UPC_EMIT:
                begin
                    w.emit   = 1'b1;
                    w.cond   = COND_OUT_FULL;
                    w.target = UPC_EMIT;
                end
                default:
                begin
                    w.emit   = 1'b1;
                    w.cond   = COND_OUT_FULL;
                    w.target = UPC_EMIT;
                end
            endcase
            return w;
        end
    endfunction

endpackage

FILE: rtl/core/pip_in_if.sv
interface pip_in_if #(
    parameter int COORD_WIDTH = pip_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic [pip_pkg::OP_W-1:0]      operation;
    logic signed [COORD_WIDTH-1:0] coord_x;
    logic signed [COORD_WIDTH-1:0] coord_y;

    modport source (output valid, output operation, output coord_x, output coord_y,
                    input ready);
    modport sink (input valid, input operation, input coord_x, input coord_y,
                  output ready);
endinterface

FILE: rtl/core/pip_out_if.sv
interface pip_out_if;
    logic                         valid;
    logic                         ready;
    logic                         inside_res;
    logic [pip_pkg::CROSS_W-1:0]  crossings;
    logic [pip_pkg::STATUS_W-1:0] status;

    modport source (output valid, output inside_res, output crossings, output status,
                    input ready);
    modport sink (input valid, input inside_res, input crossings, input status,
                  output ready);
endinterface

FILE: rtl/core/point_in_polygon_test.sv
// Point-in-polygon test by crossing number. Start and append words load the polygon
// vertices, one word per cycle while no query is in progress; a query word casts a
// rightward ray from its point and counts the crossed edges, closing edge included,
// answering inside on odd parity. A query keeps the input closed from when it is
// taken until its result is loaded: the vertex memory delivers one vertex per cycle
// to a four-stage edge pipeline whose products are compared exactly, and a small
// microcoded sequencer steps the reads, drains the pipeline and loads the result.
// A query on an empty polygon goes straight to loading the result and reports status
// empty. The result register lets loads proceed while a result waits to be taken.
module point_in_polygon_test #(
    parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
    parameter int COORD_WIDTH  = pip_pkg::COORD_WIDTH_DEF
) (
    input logic       clk,
    input logic       rst_n,
    pip_in_if.sink    request,
    pip_out_if.source result
);
    localparam int AW    = $clog2(MAX_VERTICES);
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int DW    = COORD_WIDTH + 1;
    localparam int PW    = 2 * DW;
    localparam int SW    = (CNT_W > pip_pkg::CROSS_W) ? CNT_W : pip_pkg::CROSS_W;

    pip_pkg::op_t   op;
    pip_pkg::uword_t uw;

    logic                     accept;
    logic                     query_go;
    logic                     wr_en;
    logic [AW-1:0]            waddr;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     ovf_reg, ovf_next;
    logic                     busy_reg, busy_next;
    logic                     empty_reg, empty_next;
    logic [pip_pkg::UPC_W-1:0] upc_reg, upc_next;
    logic [AW-1:0]            addr_reg, addr_next;
    logic                     addr_last;
    logic                     out_full;
    logic                     pipe_busy;
    logic                     cond_hit;
    logic                     rd_go;
    logic                     emit_go;

    logic [2*COORD_WIDTH-1:0] ram_q;

    logic                     s1_valid_reg, s1_first_reg, s1_close_reg;
    logic                     s2_valid_reg, s3_valid_reg;

    logic signed [COORD_WIDTH-1:0] px_reg, py_reg;
    logic signed [COORD_WIDTH-1:0] first_x_reg, first_y_reg;
    logic signed [COORD_WIDTH-1:0] prev_x_reg, prev_y_reg;
    logic signed [COORD_WIDTH-1:0] cur_x, cur_y;

    logic                     flip, range_ok, vert;
    logic signed [DW-1:0]     a_next, b_next, c_next, d_next;
    logic signed [DW-1:0]     s2_a_reg, s2_b_reg, s2_c_reg, s2_d_reg;
    logic                     s2_range_reg, s2_vert_reg;
    logic signed [PW-1:0]     s3_p1_reg, s3_p2_reg;
    logic                     s3_range_reg, s3_vert_reg;
    logic                     hit;
    logic [CNT_W-1:0]         hit_cnt_reg, hit_cnt_next;
    logic [SW-1:0]            hit_ext;

    logic                     out_valid_reg, out_valid_next;
    logic                     inside_reg;
    logic [pip_pkg::CROSS_W-1:0]  cross_reg;
    logic [pip_pkg::STATUS_W-1:0] status_reg;

    // load path
    assign op     = pip_pkg::op_t'(request.operation);
    assign accept = request.valid && request.ready;
    assign request.ready = !busy_reg;

    always_comb
    begin
        wr_en      = 1'b0;
        waddr      = count_reg[AW-1:0];
        count_next = count_reg;
        ovf_next   = ovf_reg;
        query_go   = 1'b0;
        if (accept)
        begin
            case (op)
                pip_pkg::OP_START:
                begin
                    wr_en      = 1'b1;
                    waddr      = '0;
                    count_next = CNT_W'(1);
                    ovf_next   = 1'b0;
                end
                pip_pkg::OP_APPEND:
                begin
                    if (count_reg < CNT_W'(MAX_VERTICES))
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                pip_pkg::OP_QUERY:
                begin
                    query_go = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    pip_ram #(
        .WIDTH (2 * COORD_WIDTH),
        .DEPTH (MAX_VERTICES)
    ) u_vertex_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (waddr),
        .wdata ({request.coord_x, request.coord_y}),
        .re    (rd_go),
        .raddr (addr_reg),
        .rdata (ram_q)
    );

    // sequencer
    assign uw        = pip_pkg::ucode(upc_reg);
    assign addr_last = CNT_W'(addr_reg) == (count_reg - CNT_W'(1));
    assign out_full  = out_valid_reg && !result.ready;
    assign pipe_busy = s1_valid_reg || s2_valid_reg || s3_valid_reg;
    assign rd_go     = busy_reg && uw.rd;
    assign emit_go   = busy_reg && uw.emit && !out_full;

    always_comb
    begin
        case (uw.cond)
            pip_pkg::COND_NEXT:      cond_hit = 1'b0;
            pip_pkg::COND_LAST:      cond_hit = addr_last;
            pip_pkg::COND_NOT_LAST:  cond_hit = !addr_last;
            pip_pkg::COND_PIPE_BUSY: cond_hit = pipe_busy;
            pip_pkg::COND_OUT_FULL:  cond_hit = out_full;
            default:                 cond_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        busy_next  = busy_reg;
        upc_next   = upc_reg;
        addr_next  = addr_reg;
        empty_next = empty_reg;
        if (busy_reg)
        begin
            upc_next = cond_hit ? uw.target : upc_reg + pip_pkg::UPC_W'(1);
            if (uw.rd)
            begin
                addr_next = addr_reg + AW'(1);
            end
            if (emit_go)
            begin
                busy_next = 1'b0;
            end
        end
        else if (query_go)
        begin
            busy_next  = 1'b1;
            addr_next  = '0;
            empty_next = (count_reg == '0);
            upc_next   = (count_reg == '0) ? pip_pkg::UPC_EMIT : pip_pkg::UPC_FIRST;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            busy_reg      <= 1'b0;
            empty_reg     <= 1'b0;
            upc_reg       <= pip_pkg::UPC_FIRST;
            addr_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            s1_first_reg  <= 1'b0;
            s1_close_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            hit_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            busy_reg      <= busy_next;
            empty_reg     <= empty_next;
            upc_reg       <= upc_next;
            addr_reg      <= addr_next;
            s1_valid_reg  <= busy_reg && (uw.rd || uw.close);
            s1_first_reg  <= busy_reg && uw.first;
            s1_close_reg  <= busy_reg && uw.close;
            s2_valid_reg  <= s1_valid_reg && !s1_first_reg;
            s3_valid_reg  <= s2_valid_reg;
            hit_cnt_reg   <= hit_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // edge pipeline: operands, products, compare and count
    assign cur_x = s1_close_reg ? first_x_reg : ram_q[2*COORD_WIDTH-1:COORD_WIDTH];
    assign cur_y = s1_close_reg ? first_y_reg : ram_q[COORD_WIDTH-1:0];

    assign flip     = cur_y < prev_y_reg;
    assign range_ok = ((py_reg > prev_y_reg) || (py_reg > cur_y))
                   && ((py_reg <= prev_y_reg) || (py_reg <= cur_y))
                   && ((px_reg <= prev_x_reg) || (px_reg <= cur_x));
    assign vert     = prev_x_reg == cur_x;
    assign a_next   = DW'(px_reg) - DW'(prev_x_reg);
    assign c_next   = DW'(py_reg) - DW'(prev_y_reg);
    assign b_next   = flip ? DW'(prev_y_reg) - DW'(cur_y) : DW'(cur_y) - DW'(prev_y_reg);
    assign d_next   = flip ? DW'(prev_x_reg) - DW'(cur_x) : DW'(cur_x) - DW'(prev_x_reg);

    assign hit = s3_valid_reg && s3_range_reg && (s3_vert_reg || (s3_p1_reg <= s3_p2_reg));

    always_comb
    begin
        hit_cnt_next = hit_cnt_reg;
        if (query_go)
        begin
            hit_cnt_next = '0;
        end
        else if (hit)
        begin
            hit_cnt_next = hit_cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (query_go)
        begin
            px_reg <= request.coord_x;
            py_reg <= request.coord_y;
        end
        if (s1_valid_reg)
        begin
            prev_x_reg <= cur_x;
            prev_y_reg <= cur_y;
        end
        if (s1_valid_reg && s1_first_reg)
        begin
            first_x_reg <= cur_x;
            first_y_reg <= cur_y;
        end
        s2_a_reg     <= a_next;
        s2_b_reg     <= b_next;
        s2_c_reg     <= c_next;
        s2_d_reg     <= d_next;
        s2_range_reg <= range_ok;
        s2_vert_reg  <= vert;
        s3_p1_reg    <= s2_a_reg * s2_b_reg;
        s3_p2_reg    <= s2_c_reg * s2_d_reg;
        s3_range_reg <= s2_range_reg;
        s3_vert_reg  <= s2_vert_reg;
    end

    // result register
    assign hit_ext = SW'(hit_cnt_reg);

    always_comb
    begin
        out_valid_next = out_valid_reg && !result.ready;
        if (emit_go)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_go)
        begin
            inside_reg <= hit_cnt_reg[0];
            cross_reg  <= (hit_ext > SW'(31)) ? pip_pkg::CROSS_W'(31)
                                              : hit_ext[pip_pkg::CROSS_W-1:0];
            if (empty_reg)
            begin
                status_reg <= pip_pkg::STATUS_EMPTY;
            end
            else if (ovf_reg)
            begin
                status_reg <= pip_pkg::STATUS_DROPPED;
            end
            else
            begin
                status_reg <= pip_pkg::STATUS_OK;
            end
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.inside_res = inside_reg;
    assign result.crossings  = cross_reg;
    assign result.status     = status_reg;

`ifndef SYNTHESIS
    a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
        query_go |=> busy_reg)
        else $error("query word did not start the sequencer");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_VERTICES))
        else $error("vertex count beyond capacity");

    a_drained_at_emit: assert property (@(posedge clk) disable iff (!rst_n)
        emit_go |-> !pipe_busy)
        else $error("result loaded with edges still in flight");

    a_hits_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (hit_cnt_reg <= count_reg))
        else $error("more crossings than edges");
`endif

endmodule

FILE: rtl/core/pip_ram.sv
module pip_ram #(
    parameter int WIDTH = 2 * pip_pkg::COORD_WIDTH_DEF,
    parameter int DEPTH = pip_pkg::MAX_VERTICES_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
